### hdl/mms_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mms_pkg - shared types and constants for the magic multiplier search
// Request and response payloads, status codes, sequencer states and the
// slot map control group.
// ----------------------------------------------------------------------------
package mms_pkg;

    localparam int unsigned MMS_MAX_INDEX_BITS = 12;
    // wide enough for popcount(64) plus the largest extra_bits code
    localparam int unsigned BITS_W             = 7;

    localparam logic [31:0] RNG_SEED           = 32'd1804289383;
    localparam logic [31:0] MAX_ATTEMPTS_RESET = 32'hFFFF_FFFF;
    // twelve generator outputs make one candidate
    localparam logic [3:0]  GEN_LAST           = 4'd11;

    typedef struct packed {
        logic [63:0] mask;
        logic [2:0]  extra_bits;
    } req_t;

    typedef enum logic [1:0] {
        STATUS_FOUND    = 2'd0,
        STATUS_LIMIT    = 2'd1,
        STATUS_BAD_MASK = 2'd2
    } status_t;

    typedef struct packed {
        logic [63:0] magic;
        status_t     status;
        logic [31:0] attempts;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COUNT,
        ST_GEN,
        ST_CLEAR,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_LOOKUP,
        ST_CHECK,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic wr_en;
        logic wr_bit;
        logic rd_en;
    } map_ctl_t;

endpackage
`default_nettype wire

### hdl/magic_multiplier_search.sv
`default_nettype none
// ----------------------------------------------------------------------------
// magic_multiplier_search - collision-free subset hash multiplier search
// Finds a 64-bit multiplier that sends every subset of a mask to its own
// slot of a 2^(popcount+extra_bits) table.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_stall/req) carries mask and extra_bits; one
//   transfer starts one search. rsp channel (rsp_valid/rsp_stall/rsp) returns
//   exactly one result per request: magic, status and attempts.
//   cfg_we/cfg_wdata write max_attempts; write only while the block is idle.
// Sequence (per request):
//   count the mask one set bit at a time; a bad mask or a zero max_attempts
//   then goes straight to the result. Else, per candidate, run the
//   generator steps, clear the 2^B slots in use, and visit each subset in
//   ST_MUL0 to ST_MUL3 on the shared 32x32 multiplier, lookup and check.
//   Then post the result. B = popcount + extra_bits. One request is in
//   flight at a time and req_stall is high while it runs.
// Reset: rst_n (async, active low) returns to idle, drops any pending
//   result, reloads the generator seed and sets max_attempts to all ones.
// Stall: a finished result is held in the output register until taken; a
//   new request may transfer in while it waits, and its result is held
//   back until the previous one has left.
// ----------------------------------------------------------------------------
module magic_multiplier_search #(
    parameter int unsigned MAX_INDEX_BITS = mms_pkg::MMS_MAX_INDEX_BITS
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire mms_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output mms_pkg::rsp_t      rsp,
    input  wire logic          cfg_we,
    input  wire logic [31:0]   cfg_wdata
);
    import mms_pkg::*;

    localparam int unsigned IDX_W = MAX_INDEX_BITS;
    localparam int unsigned CNT_W = MAX_INDEX_BITS + 1;

    function automatic logic [31:0] xorshift32(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x << 13);
        y = y ^ (y >> 17);
        y = y ^ (y << 5);
        return y;
    endfunction

    // Control registers
    state_t      state_reg, state_next;
    logic        rsp_valid_reg, rsp_valid_next;
    logic [31:0] max_attempts_reg;
    logic [31:0] rng_reg, rng_next;

    // Datapath registers
    logic [63:0]       mask_reg, mask_next;
    logic [2:0]        extra_reg, extra_next;
    logic [63:0]       pc_work_reg, pc_work_next;
    logic [BITS_W-1:0] pop_reg, pop_next;
    logic [BITS_W-1:0] bits_reg, bits_next;
    logic [3:0]        gen_cnt_reg, gen_cnt_next;
    logic [47:0]       word_reg, word_next;
    logic [63:0]       cand_reg, cand_next;
    logic [31:0]       attempt_reg, attempt_next;
    status_t           status_reg, status_next;
    logic [IDX_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [63:0]       walker_reg, walker_next;
    logic [63:0]       acc_reg, acc_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    rsp_t              rsp_reg, rsp_next;

    // Shared unit and slot map hookup
    logic [31:0]      mul_a, mul_b;
    logic [63:0]      mul_prod;
    map_ctl_t         map_ctl;
    logic [IDX_W-1:0] map_wr_addr;
    logic [IDX_W-1:0] map_rd_addr;
    logic             map_rd_bit;

    // Derived values
    logic [BITS_W-1:0] bits_calc;
    logic              mask_bad;
    logic [31:0]       rng_step;
    logic [63:0]       word_full;
    logic [CNT_W-1:0]  map_size_m1;
    logic              clr_last;
    logic [63:0]       walker_step;
    logic [31:0]       acc_hi_sum;
    logic [IDX_W-1:0]  idx_top;
    logic [BITS_W-1:0] idx_shamt;
    logic [IDX_W-1:0]  idx_calc;
    logic              rsp_load;
    logic              limit_hit;

    assign bits_calc   = pop_reg + {{(BITS_W-3){1'b0}}, extra_reg};
    assign mask_bad    = (mask_reg == 64'd0) || (bits_calc > BITS_W'(MAX_INDEX_BITS));
    assign rng_step    = xorshift32(rng_reg);
    assign word_full   = {word_reg, rng_step[15:0]};
    assign map_size_m1 = (CNT_W'(1) << bits_reg) - CNT_W'(1);
    assign clr_last    = (clr_cnt_reg == map_size_m1[IDX_W-1:0]);
    // carry-rippler: step to the next subset of the mask
    assign walker_step = (walker_reg - mask_reg) & mask_reg;
    assign acc_hi_sum  = acc_reg[63:32] + mul_prod[31:0];
    // top B bits of the low product word, B = bits_reg
    assign idx_top     = acc_reg[63 -: IDX_W];
    assign idx_shamt   = BITS_W'(MAX_INDEX_BITS) - bits_reg;
    assign idx_calc    = idx_top >> idx_shamt;
    assign rsp_load    = !rsp_valid_reg || !rsp_stall;
    assign limit_hit   = (attempt_reg == max_attempts_reg);

    mms_mul_unit u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_prod)
    );

    mms_slot_map #(
        .ADDR_W (IDX_W)
    ) u_map (
        .clk     (clk),
        .ctl     (map_ctl),
        .wr_addr (map_wr_addr),
        .rd_addr (map_rd_addr),
        .rd_bit  (map_rd_bit)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_COUNT;
                end
            end
            ST_COUNT:
            begin
                if (pc_work_reg == 64'd0)
                begin
                    if (mask_bad || (max_attempts_reg == 32'd0))
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_GEN;
                    end
                end
            end
            ST_GEN:
            begin
                if (gen_cnt_reg == GEN_LAST)
                begin
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = ST_MUL0;
                end
            end
            ST_MUL0:   state_next = ST_MUL1;
            ST_MUL1:   state_next = ST_MUL2;
            ST_MUL2:   state_next = ST_MUL3;
            ST_MUL3:   state_next = ST_LOOKUP;
            ST_LOOKUP: state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (map_rd_bit)
                begin
                    state_next = limit_hit ? ST_FINISH : ST_GEN;
                end
                else if (walker_step == 64'd0)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_MUL0;
                end
            end
            ST_FINISH:
            begin
                if (rsp_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and unit controls
    always_comb
    begin
        rng_next       = rng_reg;
        mask_next      = mask_reg;
        extra_next     = extra_reg;
        pc_work_next   = pc_work_reg;
        pop_next       = pop_reg;
        bits_next      = bits_reg;
        gen_cnt_next   = gen_cnt_reg;
        word_next      = word_reg;
        cand_next      = cand_reg;
        attempt_next   = attempt_reg;
        status_next    = status_reg;
        clr_cnt_next   = clr_cnt_reg;
        walker_next    = walker_reg;
        acc_next       = acc_reg;
        idx_next       = idx_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        mul_a          = walker_reg[31:0];
        mul_b          = cand_reg[31:0];
        map_ctl        = '0;
        map_wr_addr    = clr_cnt_reg;
        map_rd_addr    = idx_calc;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    mask_next    = req.mask;
                    pc_work_next = req.mask;
                    extra_next   = req.extra_bits;
                    pop_next     = '0;
                    cand_next    = 64'd0;
                    attempt_next = 32'd0;
                end
            end
            ST_COUNT:
            begin
                if (pc_work_reg != 64'd0)
                begin
                    // drop the lowest set bit
                    pc_work_next = pc_work_reg & (pc_work_reg - 64'd1);
                    pop_next     = pop_reg + BITS_W'(1);
                end
                else
                begin
                    bits_next    = bits_calc;
                    status_next  = mask_bad ? STATUS_BAD_MASK : STATUS_LIMIT;
                    gen_cnt_next = 4'd0;
                end
            end
            ST_GEN:
            begin
                rng_next     = rng_step;
                word_next    = word_full[47:0];
                gen_cnt_next = gen_cnt_reg + 4'd1;
                if (gen_cnt_reg[1:0] == 2'd3)
                begin
                    // first word loads, later words AND in
                    cand_next = (gen_cnt_reg == 4'd3) ? word_full : (cand_reg & word_full);
                end
                if (gen_cnt_reg == GEN_LAST)
                begin
                    attempt_next = attempt_reg + 32'd1;
                    clr_cnt_next = '0;
                end
            end
            ST_CLEAR:
            begin
                map_ctl.wr_en  = 1'b1;
                map_ctl.wr_bit = 1'b0;
                map_wr_addr    = clr_cnt_reg;
                clr_cnt_next   = clr_cnt_reg + IDX_W'(1);
                if (clr_last)
                begin
                    walker_next = 64'd0;
                end
            end
            ST_MUL0:
            begin
                mul_a = walker_reg[31:0];
                mul_b = cand_reg[31:0];
            end
            ST_MUL1:
            begin
                mul_a    = walker_reg[31:0];
                mul_b    = cand_reg[63:32];
                acc_next = mul_prod;
            end
            ST_MUL2:
            begin
                mul_a    = walker_reg[63:32];
                mul_b    = cand_reg[31:0];
                acc_next = {acc_hi_sum, acc_reg[31:0]};
            end
            ST_MUL3:
            begin
                acc_next = {acc_hi_sum, acc_reg[31:0]};
            end
            ST_LOOKUP:
            begin
                map_ctl.rd_en = 1'b1;
                map_rd_addr   = idx_calc;
                idx_next      = idx_calc;
            end
            ST_CHECK:
            begin
                if (map_rd_bit)
                begin
                    gen_cnt_next = 4'd0;
                end
                else
                begin
                    map_ctl.wr_en  = 1'b1;
                    map_ctl.wr_bit = 1'b1;
                    map_wr_addr    = idx_reg;
                    walker_next    = walker_step;
                    if (walker_step == 64'd0)
                    begin
                        status_next = STATUS_FOUND;
                    end
                end
            end
            ST_FINISH:
            begin
                if (rsp_load)
                begin
                    rsp_next.magic    = cand_reg;
                    rsp_next.status   = status_reg;
                    rsp_next.attempts = attempt_reg;
                    rsp_valid_next    = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            rsp_valid_reg    <= 1'b0;
            max_attempts_reg <= MAX_ATTEMPTS_RESET;
            rng_reg          <= RNG_SEED;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            rng_reg       <= rng_next;
            if (cfg_we)
            begin
                max_attempts_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mask_reg    <= mask_next;
        extra_reg   <= extra_next;
        pc_work_reg <= pc_work_next;
        pop_reg     <= pop_next;
        bits_reg    <= bits_next;
        gen_cnt_reg <= gen_cnt_next;
        word_reg    <= word_next;
        cand_reg    <= cand_next;
        attempt_reg <= attempt_next;
        status_reg  <= status_next;
        clr_cnt_reg <= clr_cnt_next;
        walker_reg  <= walker_next;
        acc_reg     <= acc_next;
        idx_reg     <= idx_next;
        rsp_reg     <= rsp_next;
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef NO_ASSERTIONS
    // a found multiplier always comes from at least one tested candidate
    a_found_has_attempt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && rsp_load && status_reg == STATUS_FOUND)
        |=> (rsp.attempts != 32'd0))
        else $error("found result with zero attempts");

    // an attempt-limit result reports exactly the configured limit
    a_limit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && rsp_load && status_reg == STATUS_LIMIT)
        |=> (rsp.attempts == max_attempts_reg))
        else $error("limit result attempts differ from max_attempts");

    // trial states only run with an index width the slot map can hold
    a_bits_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR || state_reg == ST_LOOKUP || state_reg == ST_CHECK)
        |-> (bits_reg != '0 && bits_reg <= BITS_W'(MAX_INDEX_BITS)))
        else $error("index width out of range during trial");

    // the generator step counter never runs past GEN_LAST while generating
    a_gen_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_GEN) |-> (gen_cnt_reg <= GEN_LAST))
        else $error("generator step counter overran");
`endif

endmodule
`default_nettype wire

### hdl/mms_mul_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mms_mul_unit - shared 32x32 multiplier
// Registered product; the sequencer feeds it one partial product per cycle.
// ----------------------------------------------------------------------------
module mms_mul_unit (
    input  wire logic        clk,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic      [63:0] prod
);

    logic [63:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(a) * 64'(b);
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

### hdl/mms_slot_map.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mms_slot_map - slot occupancy bitmap
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mms_slot_map #(
    parameter int unsigned ADDR_W = mms_pkg::MMS_MAX_INDEX_BITS
) (
    input  wire logic              clk,
    input  wire mms_pkg::map_ctl_t ctl,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic                   rd_bit
);
    import mms_pkg::*;

    localparam int unsigned DEPTH = 1 << ADDR_W;

    logic mem [DEPTH];
    logic rd_bit_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= ctl.wr_bit;
        end
        if (ctl.rd_en)
        begin
            rd_bit_reg <= mem[rd_addr];
        end
    end

    assign rd_bit = rd_bit_reg;

endmodule
`default_nettype wire
